// ===== rtl/aes_pkg.sv =====
// aes_pkg: shared types, constants and functions for the aes block encrypt pipeline
// no dependencies
`default_nettype none
package aes_pkg;

  localparam int MaxRounds = 14;
  localparam int KeyWords  = 60;

  typedef enum logic [2:0] {
    REG_KEY_LENGTH = 3'd0,
    REG_KEY_WORD_0 = 3'd1,
    REG_KEY_WORD_1 = 3'd2,
    REG_KEY_WORD_2 = 3'd3,
    REG_KEY_WORD_3 = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_len_t;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_LOAD,
    KS_RUN
  } ks_state_t;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
  } block_in_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } block_out_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [63:0] data;
  } cfg_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] word_subst(input logic [31:0] v);
    word_subst = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(4*c + w) -: 8] = SBOX[s[127 - 8*(4*((c + w) % 4) + w) -: 8]];
      end
    end
    sub_shift = r;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] r;
    logic [7:0]   a0, a1, a2, a3, al;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      al = a0 ^ a1 ^ a2 ^ a3;
      r[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      r[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      r[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      r[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    mix_columns = r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aes_block_encrypt.sv =====
// aes_block_encrypt: top level, key schedule plus fourteen round pipeline stages
// depends on aes_pkg, aes_key_sched, aes_round
`default_nettype none
// usage
//   config channel: cfg_valid/cfg_ready with cfg.index and cfg.data; index 0 is the
//   key length, 1 to 4 the key words. each transfer to index 0 to 4 reruns the key
//   expansion, one schedule word per cycle, during which cfg_ready is low and busy
//   is high; afterwards cfg_ready is high again.
//   input: a block is taken when start is high and busy is low; busy is high only
//   while the key schedule is being built, so otherwise blocks enter one per cycle.
//   output: result strobes high for one cycle with the ciphertext on result.
//   the pipeline is one stage for the initial key add and fourteen round stages;
//   shorter keys pass the unused tail stages through. throughput is one block per
//   cycle while busy is low, set by the fully unrolled round pipeline.
//   reset: the schedule of the all-zero 128-bit key is built after reset,
//   busy is high meanwhile and the pipeline is emptied.
//   the receiver cannot stall; results are never held.
module aes_block_encrypt
  import aes_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire block_in_t  block,
  output logic            busy,
  output logic            strobe,
  output block_out_t      result,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_wr_t    cfg
);

  logic [3:0]   num_rounds;
  logic [127:0] rkey [MaxRounds+1];
  logic         ks_busy;
  logic         v   [MaxRounds+1];
  logic [127:0] st  [MaxRounds+1];

  aes_key_sched u_ks (
    .clk, .rst, .cfg_valid, .cfg, .cfg_ready,
    .num_rounds, .rkey, .ks_busy
  );

  assign busy = ks_busy;

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else     v[0] <= start && !busy;
  end

  always_ff @(posedge clk) begin
    st[0] <= {block.block_high, block.block_low} ^ rkey[0];
  end

  for (genvar r = 1; r <= MaxRounds; r++) begin : g_round
    aes_round u_round (
      .clk, .rst,
      .in_valid  (v[r-1]),
      .in_state  (st[r-1]),
      .last      (num_rounds == 4'(r)),
      .bypass    (4'(r) > num_rounds),
      .rkey      (rkey[r]),
      .out_valid (v[r]),
      .out_state (st[r])
    );
  end

  assign strobe = v[MaxRounds];
  assign result = {st[MaxRounds][127:64], st[MaxRounds][63:0]};

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && busy) |=> !v[0]) else $error("block taken while busy");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##15 strobe) else $error("result missing");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !busy) else $error("config ready during expansion");
`endif

endmodule
`default_nettype wire

// ===== rtl/aes_key_sched.sv =====
// aes_key_sched: config registers and sequential key expansion into per-round key registers
// depends on aes_pkg
`default_nettype none
module aes_key_sched
  import aes_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_valid,
  input  wire cfg_wr_t        cfg,
  output logic                cfg_ready,
  output logic [3:0]          num_rounds,
  output logic [127:0]        rkey [MaxRounds+1],
  output logic                ks_busy
);

  logic [1:0]  key_length;
  logic [63:0] key_word [4];
  ks_state_t   state, state_next;
  logic [5:0]  idx;
  logic [31:0] win [8];
  logic [3:0]  nk;
  logic [2:0]  top_w;
  logic [3:0]  pos, pos_next;
  logic [3:0]  rcon_cnt;
  logic [7:0]  rcon;
  logic [31:0] t, nw;
  logic [5:0]  total;
  logic [1:0]  code;
  logic        wr;

  assign code  = (key_length == 2'd3) ? KEY_256 : key_length;
  assign nk    = 4'd4 + {1'b0, code, 1'b0};
  assign top_w = 3'(nk - 4'd1);
  assign total = {nk, 2'b00} + 6'd28;
  assign wr    = cfg_valid && cfg_ready;
  assign cfg_ready = (state == KS_IDLE);
  assign ks_busy   = (state != KS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_128;
      for (int i = 0; i < 4; i++) key_word[i] <= '0;
    end else if (wr) begin
      case (cfg.index)
        REG_KEY_LENGTH: key_length <= cfg.data[1:0];
        REG_KEY_WORD_0: key_word[0] <= cfg.data;
        REG_KEY_WORD_1: key_word[1] <= cfg.data;
        REG_KEY_WORD_2: key_word[2] <= cfg.data;
        REG_KEY_WORD_3: key_word[3] <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      KS_IDLE: if (wr && cfg.index <= REG_KEY_WORD_3) state_next = KS_LOAD;
      KS_LOAD: state_next = KS_RUN;
      KS_RUN:  if (idx == total - 6'd1) state_next = KS_IDLE;
      default: state_next = KS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= KS_LOAD;
    else     state <= state_next;
  end

  // next schedule word from the sliding window of the last nk words
  always_comb begin
    t = win[top_w];
    if (pos == 4'd0)
      t = word_subst({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
    else if (nk == 4'd8 && pos == 4'd4)
      t = word_subst(t);
    nw = win[0] ^ t;
    pos_next = (pos == nk - 4'd1) ? 4'd0 : pos + 4'd1;
  end

  always_comb begin
    case (rcon_cnt)
      4'd0: rcon = 8'h01;
      4'd1: rcon = 8'h02;
      4'd2: rcon = 8'h04;
      4'd3: rcon = 8'h08;
      4'd4: rcon = 8'h10;
      4'd5: rcon = 8'h20;
      4'd6: rcon = 8'h40;
      4'd7: rcon = 8'h80;
      4'd8: rcon = 8'h1b;
      default: rcon = 8'h36;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == KS_LOAD) begin
      for (int i = 0; i < 4; i++) begin
        win[2*i]     <= key_word[i][63:32];
        win[2*i + 1] <= key_word[i][31:0];
      end
      for (int i = 0; i < 8; i++) begin
        if (4'(i) < nk)
          rkey[i/4][127 - 32*(i%4) -: 32] <=
            (i % 2 == 1) ? key_word[i/2][31:0] : key_word[i/2][63:32];
      end
      idx        <= {2'b00, nk};
      pos        <= 4'd0;
      rcon_cnt   <= 4'd0;
      num_rounds <= nk + 4'd6;
    end else if (state == KS_RUN) begin
      for (int i = 0; i < 7; i++) begin
        if (4'(i) < nk - 4'd1) win[i] <= win[i+1];
      end
      win[top_w] <= nw;
      rkey[idx[5:2]][127 - 32*idx[1:0] -: 32] <= nw;
      idx <= idx + 6'd1;
      pos <= pos_next;
      if (pos == 4'd0) rcon_cnt <= rcon_cnt + 4'd1;
    end
  end

`ifndef SYNTHESIS
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_ready != ks_busy) else $error("ready and busy overlap");
  a_load_run: assert property (@(posedge clk) disable iff (rst)
    state == KS_LOAD |=> state == KS_RUN) else $error("load not followed by run");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == KS_RUN |-> idx < 6'(KeyWords)) else $error("schedule index overflow");
`endif

endmodule
`default_nettype wire

// ===== rtl/aes_round.sv =====
// aes_round: one registered cipher round stage with valid tracking
// depends on aes_pkg
`default_nettype none
module aes_round
  import aes_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic [127:0] in_state,
  input  wire logic         last,
  input  wire logic         bypass,
  input  wire logic [127:0] rkey,
  output logic              out_valid,
  output logic [127:0]      out_state
);

  logic [127:0] ss, mixed;

  assign ss    = sub_shift(in_state);
  assign mixed = last ? ss : mix_columns(ss);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= in_valid;
  end

  // rounds beyond the last pass the state through
  always_ff @(posedge clk) begin
    out_state <= bypass ? in_state : (mixed ^ rkey);
  end

endmodule
`default_nettype wire
